FILE: sv/gpio_controller_edge_interrupts_macros.svh
// Assertion helpers shared by the top module and the serializer.
`ifndef GPIO_CONTROLLER_EDGE_INTERRUPTS_MACROS_SVH
`define GPIO_CONTROLLER_EDGE_INTERRUPTS_MACROS_SVH

`ifndef NO_ASSERTIONS
`define GCE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GCE_ASSERT_SAME(lbl, ante, cons)
`define GCE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: sv/gce_pkg.sv
package gce_pkg;

    localparam int PORT_COUNT    = 4;
    localparam int PINS_PER_PORT = 32;
    localparam int NUM_CFG       = 4;
    localparam int PORT_IDX_W    = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

    localparam logic [31:0] PIN_MASK =
        32'((64'd1 << PINS_PER_PORT) - 64'd1);
    localparam logic [31:0] VERSION_VALUE = 32'h0100_0000;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_PIN   = 2'd2
    } gce_cmd_t;

    typedef enum logic [3:0] {
        REG_VERSION    = 4'd0,
        REG_CONFIG     = 4'd1,
        REG_SOFT_RESET = 4'd2,
        REG_SCRATCH    = 4'd3,
        REG_IRQ_ENABLE = 4'd4,
        REG_IRQ_STATUS = 4'd5,
        REG_PIN_LEVEL  = 4'd6,
        REG_PRESENT    = 4'd7,
        REG_OUT_VALUE  = 4'd8,
        REG_DIRECTION  = 4'd9,
        REG_FALL_EN    = 4'd10,
        REG_RISE_EN    = 4'd11,
        REG_PIN_INT_EN = 4'd12,
        REG_PENDING    = 4'd13
    } gce_reg_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [3:0]        port_index;
        logic [3:0]        reg_select;
        logic [31:0]       write_data;
        logic [4:0]        pin_index;
        logic signed [1:0] pin_level;
    } gce_item_t;

    typedef struct packed {
        logic [PORT_COUNT-1:0][31:0] out_value;
        logic [PORT_COUNT-1:0][31:0] direction;
        logic [PORT_COUNT-1:0][31:0] rise_enable;
        logic [PORT_COUNT-1:0][31:0] fall_enable;
        logic [PORT_COUNT-1:0][31:0] pin_int_enable;
        logic [PORT_COUNT-1:0][31:0] pending;
        logic [PORT_COUNT-1:0][31:0] level_seen;
        logic [PORT_COUNT-1:0][31:0] ext_level;
        logic [PORT_COUNT-1:0][31:0] ext_driven;
        logic [PORT_COUNT-1:0][31:0] drv_mask;
        logic [PORT_COUNT-1:0][31:0] drive_level;
        logic [31:0]                 soft_reset;
        logic [31:0]                 scratch;
        logic [PORT_COUNT-1:0]       irq_enable;
        logic [PORT_COUNT-1:0]       irq_status;
        logic                        irq;
    } gce_state_t;

    // soft reset held, everything else cleared
    localparam gce_state_t STATE_RESET = '{soft_reset: 32'd1, default: '0};

    typedef struct packed {
        logic [31:0]                 rd;
        logic                        err;
        logic                        irq;
        logic [PORT_COUNT-1:0][31:0] drv_en;
        logic [PORT_COUNT-1:0][31:0] drv_val;
    } gce_snap_t;

endpackage

FILE: sv/gpio_controller_edge_interrupts.sv
// Four-port GPIO controller with edge interrupts. Each input beat is a register read, a
// register write or an external pin event; it is registered, then processed against the
// port state, and yields four result beats, one per port, carrying read data, error
// flag, interrupt line and that port's drive state (last marks the final port).
// Sustained throughput is set by the output port, which can be held by out_ready; a new
// item is taken while the previous item's results are still being delivered.
// present_port registers are written through the cfg channel, which is always ready.
`include "gpio_controller_edge_interrupts_macros.svh"

module gpio_controller_edge_interrupts
    import gce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [3:0]         port_index,
    input  logic [3:0]         reg_select,
    input  logic [31:0]        write_data,
    input  logic [4:0]         pin_index,
    input  logic signed [1:0]  pin_level,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        read_data,
    output logic               access_error,
    output logic               irq_level,
    output logic [1:0]         report_port,
    output logic [31:0]        drive_enable,
    output logic [31:0]        drive_value,
    output logic               last
);

    logic [NUM_CFG-1:0][31:0] present_reg;
    gce_item_t                item_reg;
    logic                     item_valid_reg;
    gce_state_t               state_reg;
    gce_state_t               state_next;
    gce_snap_t                snap;
    logic                     push_ready;
    logic                     advance;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid_reg && push_ready;
    assign in_ready  = !item_valid_reg || push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            present_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{cmd: cmd, port_index: port_index, reg_select: reg_select,
                          write_data: write_data, pin_index: pin_index,
                          pin_level: pin_level};
        end
    end

    gce_eval u_eval (
        .item    (item_reg),
        .st      (state_reg),
        .present (present_reg),
        .ns      (state_next),
        .snap    (snap)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    gce_ser u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_valid   (item_valid_reg),
        .push_ready   (push_ready),
        .snap         (snap),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .access_error (access_error),
        .irq_level    (irq_level),
        .report_port  (report_port),
        .drive_enable (drive_enable),
        .drive_value  (drive_value),
        .last         (last)
    );

    `GCE_ASSERT_NEXT(a_read_no_change, advance && item_reg.cmd == CMD_READ, $stable(state_reg))
    `GCE_ASSERT_NEXT(a_soft_reset_hold,
                     advance && state_reg.soft_reset != '0 &&
                     !(item_reg.cmd == CMD_WRITE && item_reg.reg_select == REG_SOFT_RESET),
                     $stable(state_reg.irq) && $stable(state_reg.irq_status))
    `GCE_ASSERT_SAME(a_irq_needs_status, state_reg.irq, state_reg.irq_status != '0)

endmodule

FILE: sv/gce_eval.sv
module gce_eval
    import gce_pkg::*;
(
    input  gce_item_t                   item,
    input  gce_state_t                  st,
    input  logic [NUM_CFG-1:0][31:0]    present,
    output gce_state_t                  ns,
    output gce_snap_t                   snap
);

    logic [PORT_COUNT-1:0][31:0] eff_pres;
    logic                        port_ok;
    logic                        pin_ok;
    logic [PORT_IDX_W-1:0]       pidx;
    logic [31:0]                 pres_sel;
    logic [31:0]                 m;
    logic [31:0]                 pin_bit;
    logic                        do_eval;
    logic                        err;
    logic [31:0]                 rd;
    logic [31:0]                 extd;
    logic [31:0]                 oe;
    logic [31:0]                 val;
    logic [31:0]                 chg;
    logic [31:0]                 upd;

    always_comb
    begin
        for (int p = 0; p < PORT_COUNT; p++)
        begin
            eff_pres[p] = present[p] & PIN_MASK;
        end
        port_ok  = {1'b0, item.port_index} < 5'(PORT_COUNT);
        pin_ok   = {1'b0, item.pin_index} < 6'(PINS_PER_PORT);
        pidx     = item.port_index[PORT_IDX_W-1:0];
        pres_sel = port_ok ? eff_pres[pidx] : '0;
        m        = item.write_data & pres_sel;
        pin_bit  = 32'd1 << item.pin_index;
    end

    always_comb
    begin
        ns      = st;
        err     = 1'b0;
        rd      = '0;
        do_eval = 1'b0;
        extd    = '0;
        oe      = '0;
        val     = '0;
        chg     = '0;
        upd     = '0;

        case (item.cmd)
            CMD_READ:
            begin
                case (item.reg_select)
                    REG_VERSION:    rd = VERSION_VALUE;
                    REG_CONFIG:     rd = 32'(PORT_COUNT);
                    REG_SOFT_RESET: rd = st.soft_reset;
                    REG_SCRATCH:    rd = st.scratch;
                    REG_IRQ_ENABLE: rd = 32'(st.irq_enable);
                    REG_IRQ_STATUS: rd = 32'(st.irq_status);
                    REG_PIN_LEVEL:  rd = port_ok ? st.level_seen[pidx] & pres_sel : '0;
                    REG_PRESENT:    rd = pres_sel;
                    REG_OUT_VALUE:  rd = port_ok ? st.out_value[pidx] & pres_sel : '0;
                    REG_DIRECTION:  rd = port_ok ? st.direction[pidx] & pres_sel : '0;
                    REG_FALL_EN:    rd = port_ok ? st.fall_enable[pidx] & pres_sel : '0;
                    REG_RISE_EN:    rd = port_ok ? st.rise_enable[pidx] & pres_sel : '0;
                    REG_PIN_INT_EN: rd = port_ok ? st.pin_int_enable[pidx] & pres_sel : '0;
                    REG_PENDING:    rd = port_ok ? st.pending[pidx] & pres_sel : '0;
                    default:        err = 1'b1;
                endcase
                if (item.reg_select >= REG_PIN_LEVEL && !port_ok)
                begin
                    err = 1'b1;
                end
            end
            CMD_WRITE:
            begin
                case (item.reg_select)
                    REG_SOFT_RESET:
                    begin
                        ns.soft_reset = item.write_data;
                        do_eval       = 1'b1;
                    end
                    REG_SCRATCH:
                    begin
                        ns.scratch = item.write_data;
                        do_eval    = 1'b1;
                    end
                    REG_IRQ_ENABLE:
                    begin
                        ns.irq_enable = item.write_data[PORT_COUNT-1:0];
                        do_eval       = 1'b1;
                    end
                    REG_VERSION, REG_CONFIG, REG_IRQ_STATUS:
                    begin
                        err     = 1'b1;
                        do_eval = 1'b1;
                    end
                    REG_PIN_LEVEL, REG_PRESENT:
                    begin
                        err     = 1'b1;
                        do_eval = port_ok;
                    end
                    REG_OUT_VALUE, REG_DIRECTION, REG_FALL_EN, REG_RISE_EN,
                    REG_PIN_INT_EN, REG_PENDING:
                    begin
                        if (!port_ok)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            do_eval = 1'b1;
                            case (item.reg_select)
                                REG_OUT_VALUE:  ns.out_value[pidx]      = m;
                                REG_DIRECTION:  ns.direction[pidx]      = m;
                                REG_FALL_EN:    ns.fall_enable[pidx]    = m;
                                REG_RISE_EN:    ns.rise_enable[pidx]    = m;
                                REG_PIN_INT_EN: ns.pin_int_enable[pidx] = m;
                                default:        ns.pending[pidx] = st.pending[pidx] & ~m;
                            endcase
                        end
                    end
                    default:
                    begin
                        err     = 1'b1;
                        do_eval = 1'b1;
                    end
                endcase
            end
            CMD_PIN:
            begin
                if (!port_ok || !pin_ok)
                begin
                    err = 1'b1;
                end
                else
                begin
                    do_eval = 1'b1;
                    if (item.pin_level[1])
                    begin
                        ns.ext_driven[pidx] = st.ext_driven[pidx] & ~pin_bit;
                    end
                    else
                    begin
                        ns.ext_driven[pidx] = st.ext_driven[pidx] | pin_bit;
                        if (item.pin_level[0])
                        begin
                            ns.ext_level[pidx] = st.ext_level[pidx] | pin_bit;
                        end
                        else
                        begin
                            ns.ext_level[pidx] = st.ext_level[pidx] & ~pin_bit;
                        end
                    end
                end
            end
            default: err = 1'b1;
        endcase

        // pin evaluation, per-port lanes
        if (do_eval && ns.soft_reset == '0)
        begin
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                extd = eff_pres[p] & ns.ext_driven[p];
                oe   = eff_pres[p] & ns.direction[p];
                val  = ((extd & ns.ext_level[p]) | (~extd & oe & ns.out_value[p])) & PIN_MASK;
                chg  = (val ^ ns.level_seen[p]) & eff_pres[p];
                ns.level_seen[p] = (ns.level_seen[p] & ~PIN_MASK) | val;
                ns.pending[p] = ns.pending[p]
                    | (chg & ((val & ns.rise_enable[p]) | (~val & ns.fall_enable[p])));
                upd = ((ns.drv_mask[p] ^ oe) | (oe & (ns.drive_level[p] ^ ns.out_value[p])))
                    & PIN_MASK;
                ns.drv_mask[p]    = (ns.drv_mask[p] & ~upd) | (oe & upd);
                ns.drive_level[p] = (ns.drive_level[p] & ~upd) | (ns.out_value[p] & upd);
                ns.irq_status[p]  = (ns.pending[p] & ns.pin_int_enable[p]) != '0;
            end
            ns.irq = (ns.irq_status & ns.irq_enable) != '0;
        end
    end

    always_comb
    begin
        snap.rd      = err ? '0 : rd;
        snap.err     = err;
        snap.irq     = ns.irq;
        snap.drv_en  = ns.drv_mask;
        snap.drv_val = ns.drive_level & ns.drv_mask;
    end

endmodule

FILE: sv/gce_ser.sv
`include "gpio_controller_edge_interrupts_macros.svh"

module gce_ser
    import gce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  gce_snap_t   snap,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        access_error,
    output logic        irq_level,
    output logic [1:0]  report_port,
    output logic [31:0] drive_enable,
    output logic [31:0] drive_value,
    output logic        last
);

    gce_snap_t             snap_reg;
    logic                  valid_reg;
    logic                  valid_next;
    logic [PORT_IDX_W-1:0] beat_reg;
    logic [PORT_IDX_W-1:0] beat_next;
    logic                  is_last;
    logic                  done;
    logic                  push;

    assign is_last    = beat_reg == PORT_IDX_W'(PORT_COUNT - 1);
    assign done       = valid_reg && out_ready && is_last;
    assign push_ready = !valid_reg || done;
    assign push       = push_valid && push_ready;

    always_comb
    begin
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (push)
        begin
            valid_next = 1'b1;
            beat_next  = '0;
        end
        else if (done)
        begin
            valid_next = 1'b0;
            beat_next  = '0;
        end
        else if (valid_reg && out_ready)
        begin
            beat_next = beat_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            snap_reg <= snap;
        end
    end

    assign out_valid    = valid_reg;
    assign read_data    = snap_reg.rd;
    assign access_error = snap_reg.err;
    assign irq_level    = snap_reg.irq;
    assign report_port  = 2'(beat_reg);
    assign drive_enable = snap_reg.drv_en[beat_reg];
    assign drive_value  = snap_reg.drv_val[beat_reg];
    assign last         = is_last;

    `GCE_ASSERT_NEXT(a_beat_step, out_valid && out_ready && !last,
                     out_valid && report_port == $past(report_port) + 2'd1)
    `GCE_ASSERT_SAME(a_push_on_last, push && valid_reg, out_ready && last)
    `GCE_ASSERT_NEXT(a_drain, out_valid && out_ready && last && !push_valid, !out_valid)

endmodule

FILE: sim/gpio_controller_edge_interrupts_tb.sv
`timescale 1ns / 100ps

module gpio_controller_edge_interrupts_tb;
    import gce_pkg::*;

    localparam logic [1:0] CMD_BAD = 2'd3;
    localparam logic [3:0] REG_BAD_LO = 4'd14;
    localparam logic [3:0] REG_BAD_HI = 4'd15;
    localparam logic signed [1:0] LVL_LOW = 2'sd0;
    localparam logic signed [1:0] LVL_HIGH = 2'sd1;
    localparam logic signed [1:0] LVL_RELEASE = -2'sd1;
    localparam logic signed [1:0] LVL_RELEASE_ALT = -2'sd2;
    localparam logic [1:0] CFG_PRESENT_PORT0 = 2'd0;
    localparam logic [1:0] CFG_PRESENT_PORT1 = 2'd1;
    localparam logic [1:0] CFG_PRESENT_PORT2 = 2'd2;
    localparam logic [1:0] CFG_PRESENT_PORT3 = 2'd3;
    localparam logic [31:0] ALL_PINS = 32'hFFFF_FFFF;
    localparam int ITEMS_PER_PHASE = 25;
    localparam int NUM_PHASES = 5;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        logic [31:0] rd;
        logic        err;
        logic        irq;
        logic [1:0]  port;
        logic [31:0] en;
        logic [31:0] val;
        logic        last;
    } port_report_t;

    typedef struct {
        logic [1:0]        c;
        logic [3:0]        port;
        logic [3:0]        rsel;
        logic [31:0]       wd;
        logic [4:0]        pin;
        logic signed [1:0] lvl;
        bit                typed;
        logic [31:0]       rd;
        logic              err;
    } access_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] cmd = '0;
    logic [3:0] port_index = '0;
    logic [3:0] reg_select = '0;
    logic [31:0] write_data = '0;
    logic [4:0] pin_index = '0;
    logic signed [1:0] pin_level = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [31:0] read_data;
    logic access_error;
    logic irq_level;
    logic [1:0] report_port;
    logic [31:0] drive_enable;
    logic [31:0] drive_value;
    logic last;

    gpio_controller_edge_interrupts DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .port_index(port_index),
        .reg_select(reg_select),
        .write_data(write_data),
        .pin_index(pin_index),
        .pin_level(pin_level),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .read_data(read_data),
        .access_error(access_error),
        .irq_level(irq_level),
        .report_port(report_port),
        .drive_enable(drive_enable),
        .drive_value(drive_value),
        .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted controller state
    logic [31:0] present_mask [PORT_COUNT] = '{default: ALL_PINS};
    logic [31:0] out_word [PORT_COUNT] = '{default: '0};
    logic [31:0] dir_word [PORT_COUNT] = '{default: '0};
    logic [31:0] rise_word [PORT_COUNT] = '{default: '0};
    logic [31:0] fall_word [PORT_COUNT] = '{default: '0};
    logic [31:0] int_en_word [PORT_COUNT] = '{default: '0};
    logic [31:0] pending_word [PORT_COUNT] = '{default: '0};
    logic [31:0] level_word [PORT_COUNT] = '{default: '0};
    logic [31:0] ext_level_word [PORT_COUNT] = '{default: '0};
    logic [31:0] ext_driven_word [PORT_COUNT] = '{default: '0};
    logic [31:0] drv_mask_word [PORT_COUNT] = '{default: '0};
    logic [31:0] drv_level_word [PORT_COUNT] = '{default: '0};
    logic [31:0] soft_reset_word = 32'd1;
    logic [31:0] scratch_word = '0;
    logic [PORT_COUNT-1:0] port_irq_en = '0;
    logic [PORT_COUNT-1:0] port_irq_stat = '0;
    logic irq_line = 1'b0;

    port_report_t port_reports_q [$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;
    bit hold_off = 1'b0;

    access_row_t opening_rows [28] = '{
        '{CMD_READ,  4'd0,  REG_VERSION,    32'h0,        5'd0,  LVL_LOW, 1'b1, VERSION_VALUE, 1'b0},
        '{CMD_READ,  4'd0,  REG_CONFIG,     32'h0,        5'd0,  LVL_LOW, 1'b1, 32'd4,         1'b0},
        '{CMD_READ,  4'd0,  REG_SOFT_RESET, 32'h0,        5'd0,  LVL_LOW, 1'b1, 32'd1,         1'b0},
        '{CMD_WRITE, 4'd0,  REG_DIRECTION,  ALL_PINS,     5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_WRITE, 4'd0,  REG_SOFT_RESET, 32'h0,        5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_WRITE, 4'd0,  REG_OUT_VALUE,  32'hA5A5A5A5, 5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_WRITE, 4'd0,  REG_FALL_EN,    ALL_PINS,     5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_WRITE, 4'd0,  REG_RISE_EN,    ALL_PINS,     5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_WRITE, 4'd0,  REG_PIN_INT_EN, ALL_PINS,     5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_WRITE, 4'd9,  REG_IRQ_ENABLE, ALL_PINS,     5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_PIN,   4'd0,  REG_VERSION,    32'h0,        5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_READ,  4'd0,  REG_PENDING,    32'h0,        5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_READ,  4'd0,  REG_IRQ_STATUS, 32'h0,        5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_PIN,   4'd3,  REG_VERSION,    32'h0,        5'd31, LVL_HIGH, 1'b0, 32'h0,        1'b0},
        '{CMD_READ,  4'd3,  REG_PIN_LEVEL,  32'h0,        5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_WRITE, 4'd0,  REG_PENDING,    ALL_PINS,     5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_PIN,   4'd0,  REG_VERSION,    32'h0,        5'd0,  LVL_RELEASE_ALT, 1'b0, 32'h0, 1'b0},
        '{CMD_PIN,   4'd4,  REG_VERSION,    32'h0,        5'd0,  LVL_HIGH, 1'b1, 32'h0,        1'b1},
        '{CMD_READ,  4'd15, REG_OUT_VALUE,  32'h0,        5'd0,  LVL_LOW, 1'b1, 32'h0,         1'b1},
        '{CMD_READ,  4'd0,  REG_BAD_LO,     32'h0,        5'd0,  LVL_LOW, 1'b1, 32'h0,         1'b1},
        '{CMD_WRITE, 4'd0,  REG_BAD_HI,     ALL_PINS,     5'd0,  LVL_LOW, 1'b1, 32'h0,         1'b1},
        '{CMD_WRITE, 4'd0,  REG_VERSION,    ALL_PINS,     5'd0,  LVL_LOW, 1'b1, 32'h0,         1'b1},
        '{CMD_BAD,   4'd15, REG_BAD_HI,     ALL_PINS,     5'd31, LVL_RELEASE, 1'b1, 32'h0,     1'b1},
        '{CMD_WRITE, 4'd0,  REG_SCRATCH,    ALL_PINS,     5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_READ,  4'd0,  REG_SCRATCH,    32'h0,        5'd0,  LVL_LOW, 1'b1, ALL_PINS,      1'b0},
        '{CMD_WRITE, 4'd0,  REG_SOFT_RESET, 32'h80000000, 5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_WRITE, 4'd0,  REG_PENDING,    ALL_PINS,     5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0},
        '{CMD_READ,  4'd0,  REG_IRQ_STATUS, 32'h0,        5'd0,  LVL_LOW, 1'b0, 32'h0,         1'b0}
    };

    function automatic logic [31:0] port_present(input int unsigned p);
        if (p >= PORT_COUNT)
            return '0;
        return present_mask[p] & PIN_MASK;
    endfunction

    // pin levels, edge capture, drive state, then port summary and irq line
    function automatic void settle_pins();
        logic [31:0] pres;
        logic [31:0] extd;
        logic [31:0] oe;
        logic [31:0] o;
        logic [31:0] val;
        logic [31:0] chg;
        logic [31:0] upd;
        if (soft_reset_word != '0)
            return;
        for (int p = 0; p < PORT_COUNT; p++)
        begin
            pres = port_present(p);
            extd = pres & ext_driven_word[p];
            oe = pres & dir_word[p];
            o = out_word[p];
            val = ((extd & ext_level_word[p]) | (~extd & oe & o)) & PIN_MASK;
            chg = (val ^ level_word[p]) & pres;
            level_word[p] = (level_word[p] & ~PIN_MASK) | val;
            pending_word[p] |= chg & ((val & rise_word[p]) | (~val & fall_word[p]));
            upd = ((drv_mask_word[p] ^ oe) | (oe & (drv_level_word[p] ^ o))) & PIN_MASK;
            drv_mask_word[p] = (drv_mask_word[p] & ~upd) | (oe & upd);
            drv_level_word[p] = (drv_level_word[p] & ~upd) | (o & upd);
        end
        for (int p = 0; p < PORT_COUNT; p++)
            port_irq_stat[p] = (pending_word[p] & int_en_word[p]) != '0;
        irq_line = (port_irq_stat & port_irq_en) != '0;
    endfunction

    function automatic void execute_access(input gce_item_t it, output logic [31:0] rd,
                                           output logic err);
        int unsigned p;
        logic [31:0] pres;
        logic [31:0] m;
        logic [31:0] pin_bit;
        rd = '0;
        err = 1'b0;
        p = it.port_index;
        pres = port_present(p);
        case (it.cmd)
            CMD_READ:
            begin
                case (it.reg_select)
                    REG_VERSION:    rd = VERSION_VALUE;
                    REG_CONFIG:     rd = 32'(PORT_COUNT);
                    REG_SOFT_RESET: rd = soft_reset_word;
                    REG_SCRATCH:    rd = scratch_word;
                    REG_IRQ_ENABLE: rd = 32'(port_irq_en);
                    REG_IRQ_STATUS: rd = 32'(port_irq_stat);
                    default:
                    begin
                        if (it.reg_select > REG_PENDING || p >= PORT_COUNT)
                            err = 1'b1;
                        else
                        begin
                            case (it.reg_select)
                                REG_PIN_LEVEL:  rd = level_word[p] & pres;
                                REG_PRESENT:    rd = pres;
                                REG_OUT_VALUE:  rd = out_word[p] & pres;
                                REG_DIRECTION:  rd = dir_word[p] & pres;
                                REG_FALL_EN:    rd = fall_word[p] & pres;
                                REG_RISE_EN:    rd = rise_word[p] & pres;
                                REG_PIN_INT_EN: rd = int_en_word[p] & pres;
                                default:        rd = pending_word[p] & pres;
                            endcase
                        end
                    end
                endcase
            end
            CMD_WRITE:
            begin
                if (it.reg_select <= REG_IRQ_STATUS || it.reg_select > REG_PENDING)
                begin
                    case (it.reg_select)
                        REG_SOFT_RESET: soft_reset_word = it.write_data;
                        REG_SCRATCH:    scratch_word = it.write_data;
                        REG_IRQ_ENABLE: port_irq_en = it.write_data[PORT_COUNT-1:0];
                        default:        err = 1'b1;
                    endcase
                    settle_pins();
                end
                else if (p >= PORT_COUNT)
                    err = 1'b1;
                else
                begin
                    m = it.write_data & pres;
                    case (it.reg_select)
                        REG_OUT_VALUE:  out_word[p] = m;
                        REG_DIRECTION:  dir_word[p] = m;
                        REG_FALL_EN:    fall_word[p] = m;
                        REG_RISE_EN:    rise_word[p] = m;
                        REG_PIN_INT_EN: int_en_word[p] = m;
                        REG_PENDING:    pending_word[p] &= ~m;
                        default:        err = 1'b1;
                    endcase
                    settle_pins();
                end
            end
            CMD_PIN:
            begin
                if (p >= PORT_COUNT || it.pin_index >= PINS_PER_PORT)
                    err = 1'b1;
                else
                begin
                    pin_bit = 32'd1 << it.pin_index;
                    if (it.pin_level[1])
                        ext_driven_word[p] &= ~pin_bit;
                    else
                    begin
                        ext_driven_word[p] |= pin_bit;
                        if (it.pin_level != LVL_LOW)
                            ext_level_word[p] |= pin_bit;
                        else
                            ext_level_word[p] &= ~pin_bit;
                    end
                    settle_pins();
                end
            end
            default: err = 1'b1;
        endcase
        if (err)
            rd = '0;
    endfunction

    function automatic gce_item_t random_access();
        gce_item_t it;
        int unsigned pick;
        it.cmd = CMD_READ;
        it.port_index = 4'($urandom_range(0, PORT_COUNT - 1));
        it.reg_select = 4'($urandom_range(0, 15));
        it.pin_index = 5'($urandom_range(0, 31));
        it.pin_level = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0:       it.write_data = '0;
            1:       it.write_data = ALL_PINS;
            default: it.write_data = $urandom;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            it.cmd = CMD_WRITE;
            it.reg_select = 4'($urandom_range(int'(REG_OUT_VALUE), int'(REG_PENDING)));
        end
        else if (pick < 65)
            it.cmd = CMD_PIN;
        else if (pick < 83)
            it.cmd = CMD_READ;
        else if (pick < 91)
        begin
            it.cmd = CMD_WRITE;
            it.reg_select = 4'($urandom_range(int'(REG_SOFT_RESET), int'(REG_IRQ_ENABLE)));
            if (it.reg_select == REG_SOFT_RESET && $urandom_range(0, 3) != 0)
                it.write_data = '0;
        end
        else
        begin
            it.cmd = 2'($urandom_range(0, 3));
            it.port_index = 4'($urandom_range(0, 15));
        end
        return it;
    endfunction

    task automatic offer_access(input gce_item_t it, input bit typed,
                                input logic [31:0] typed_rd, input logic typed_err);
        int gap;
        logic [31:0] rd;
        logic err;
        port_report_t rep;
        gap = tx_eager ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= it.cmd;
        port_index <= it.port_index;
        reg_select <= it.reg_select;
        write_data <= it.write_data;
        pin_index <= it.pin_index;
        pin_level <= it.pin_level;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        execute_access(it, rd, err);
        if (typed)
        begin
            rd = typed_rd;
            err = typed_err;
        end
        for (int k = 0; k < PORT_COUNT; k++)
        begin
            rep.rd = rd;
            rep.err = err;
            rep.irq = irq_line;
            rep.port = 2'(k);
            rep.en = drv_mask_word[k];
            rep.val = drv_level_word[k] & drv_mask_word[k];
            rep.last = (k == PORT_COUNT - 1);
            port_reports_q.push_back(rep);
        end
    endtask

    task automatic load_present(input logic [31:0] m0, input logic [31:0] m1,
                                input logic [31:0] m2, input logic [31:0] m3);
        logic [31:0] masks [NUM_CFG];
        logic [1:0] idx [NUM_CFG];
        masks = '{m0, m1, m2, m3};
        idx = '{CFG_PRESENT_PORT0, CFG_PRESENT_PORT1, CFG_PRESENT_PORT2, CFG_PRESENT_PORT3};
        for (int i = 0; i < NUM_CFG; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= masks[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            present_mask[idx[i]] = masks[i];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        while (port_reports_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_report();
        port_report_t want;
        if (port_reports_q.size() == 0)
        begin
            $error("report beat for port %0d with nothing outstanding", report_port);
            mismatches++;
            return;
        end
        want = port_reports_q.pop_front();
        check_field("read_data", want.rd, read_data);
        check_field("access_error", 32'(want.err), 32'(access_error));
        check_field("irq_level", 32'(want.irq), 32'(irq_level));
        check_field("report_port", 32'(want.port), 32'(report_port));
        check_field("drive_enable", want.en, drive_enable);
        check_field("drive_value", want.val, drive_value);
        check_field("last", 32'(want.last), 32'(last));
    endtask

    // result side: per-beat backpressure, with one long hold-off on request
    initial
    begin : report_sink
        int wait_cycles;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off)
            begin
                hold_off = 1'b0;
                wait_cycles = HOLD_OFF_CYCLES;
            end
            else
                wait_cycles = rx_eager ? 0 : $urandom_range(0, 7);
            if (wait_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            check_report();
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        gce_item_t it;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_rows[i])
        begin
            it.cmd = opening_rows[i].c;
            it.port_index = opening_rows[i].port;
            it.reg_select = opening_rows[i].rsel;
            it.write_data = opening_rows[i].wd;
            it.pin_index = opening_rows[i].pin;
            it.pin_level = opening_rows[i].lvl;
            offer_access(it, opening_rows[i].typed, opening_rows[i].rd, opening_rows[i].err);
        end
        drain_reports();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: load_present(ALL_PINS, ALL_PINS, ALL_PINS, ALL_PINS);
                1: load_present(ALL_PINS, 32'h0, 32'h0000_FFFF, 32'h8000_0001);
                2: load_present($urandom, $urandom, $urandom, $urandom);
                3: load_present(32'h0, 32'h0, 32'h0, 32'h0);
                default: load_present(32'h5A5A_F00F, ALL_PINS, $urandom, ALL_PINS);
            endcase
            tx_eager = (phase <= 1);
            rx_eager = (phase == 0);
            // receiver stalls while the sender keeps offering beats
            hold_off = (phase == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                offer_access(random_access(), 1'b0, '0, 1'b0);
            drain_reports();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && port_reports_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
